@@ src/swpf_pkg.sv @@
// shared types and constants for the shallow-water point flux block
package swpf_pkg;

  // problem dimension; one dimension ignores the y momentum
  localparam int DIMENSION = 2;

  localparam logic [21:0] GRAVITY_RESET = 22'd642908;

  // step counts of the shared divide / square root unit
  localparam logic [5:0] DIV_STEPS  = 6'd31;
  localparam logic [5:0] SQRT_STEPS = 6'd32;

  typedef enum logic [0:0] {
    DSU_DIV,
    DSU_SQRT
  } dsu_op_t;

  // request to the divide / square root unit
  typedef struct packed {
    logic        start;
    dsu_op_t     op;
    logic [33:0] rem_init;
    logic [63:0] x_init;
    logic [23:0] divisor;
  } dsu_req_t;

  // status back from the divide / square root unit
  typedef struct packed {
    logic busy;
    logic done;
  } dsu_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DX,
    ST_DXW,
    ST_DY,
    ST_DYW,
    ST_M0,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_M5,
    ST_M6,
    ST_M7,
    ST_M8,
    ST_M9,
    ST_SQA,
    ST_SQAW,
    ST_SQB,
    ST_SQBW,
    ST_FIN
  } swpf_state_t;

endpackage

@@ src/swpf_mul.sv @@
// shared unsigned 32x32 multiplier with registered product
module swpf_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);
  import swpf_pkg::*;

  logic [63:0] p_r;

  // product register
  always_ff @(posedge clk) begin
    p_r <= {32'b0, a} * {32'b0, b};
  end

  assign p = p_r;

endmodule

@@ src/swpf_dsu.sv @@
// shared iterative unit: restoring divide, one bit a cycle, and digit square root
module swpf_dsu (
  input  logic               clk,
  input  logic               rst_n,
  input  swpf_pkg::dsu_req_t req,
  output swpf_pkg::dsu_stat_t stat,
  output logic [31:0]        res
);
  import swpf_pkg::*;

  dsu_op_t     op_r;
  logic [33:0] rem_r;
  logic [63:0] x_r;
  logic [31:0] root_r;
  logic [23:0] div_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;

  logic [33:0] cand;
  logic [33:0] trial;
  logic        ge;

  // trial subtract of one step
  always_comb begin
    if (op_r == DSU_DIV) begin
      cand  = {rem_r[32:0], x_r[63]};
      trial = {10'b0, div_r};
    end else begin
      cand  = {rem_r[31:0], x_r[63:62]};
      trial = {root_r, 2'b01};
    end
    ge = (cand >= trial);
  end

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= (req.op == DSU_DIV) ? DIV_STEPS : SQRT_STEPS;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r   <= req.op;
      rem_r  <= req.rem_init;
      x_r    <= req.x_init;
      div_r  <= req.divisor;
      root_r <= 32'd0;
    end else if (busy_r) begin
      rem_r  <= ge ? (cand - trial) : cand;
      root_r <= {root_r[30:0], ge};
      x_r    <= (op_r == DSU_DIV) ? {x_r[62:0], 1'b0} : {x_r[61:0], 2'b00};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign res       = root_r;

endmodule

@@ src/shallow_water_point_flux.sv @@
// top level: shallow-water flux tensor and wave speed of one point, with running maxima
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_ready   | height, momentum_x/y, last_in_cell, start_sweep
//   out     | output    | out_valid / out_ready | four fluxes, speeds, zero_height, cell_done
//   cfg     | input     | cfg_we                | gravity
//
// Each word runs two 31-step divides and two 32-step square roots on the shared
// unit (request, steps, done), the multiplier states M0 to M9 on the shared
// multiplier, and the finish and idle states.
// Reset is synchronous, active low; it clears gravity to 9.81 and both maxima to zero.
// A word is taken only in the idle state; a finished result waits in the output
// register, and the next word is taken while it waits.
module shallow_water_point_flux (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [21:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [23:0]        in_height,
  input  logic signed [24:0] in_momentum_x,
  input  logic signed [24:0] in_momentum_y,
  input  logic               in_last_in_cell,
  input  logic               in_start_sweep,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_flux_xx,
  output logic signed [31:0] out_flux_xy,
  output logic signed [31:0] out_flux_yx,
  output logic signed [31:0] out_flux_yy,
  output logic [31:0]        out_wave_speed,
  output logic [31:0]        out_cell_max_speed,
  output logic [31:0]        out_domain_max_speed,
  output logic               out_zero_height,
  output logic               out_cell_done
);
  import swpf_pkg::*;

  // saturate a nonnegative sum to the signed 32-bit range
  function automatic logic [31:0] sat_pos(input logic [40:0] v);
    logic [31:0] r;
    if (|v[40:31]) r = 32'h7FFF_FFFF;
    else           r = {1'b0, v[30:0]};
    return r;
  endfunction

  // saturate a sign and magnitude to the signed 32-bit range
  function automatic logic [31:0] sat_sm(input logic neg, input logic [39:0] mag);
    logic [31:0] r;
    if (neg) begin
      if (mag > 40'h00_8000_0000) r = 32'h8000_0000;
      else                        r = ~mag[31:0] + 32'd1;
    end else begin
      if (mag > 40'h00_7FFF_FFFF) r = 32'h7FFF_FFFF;
      else                        r = mag[31:0];
    end
    return r;
  endfunction

  swpf_state_t state_r, state_nxt;

  logic [21:0] gravity_r;
  logic [31:0] cell_max_r, cell_max_nxt;
  logic [31:0] dom_max_r, dom_max_nxt;
  logic        out_valid_r;

  logic [23:0] h_r;
  logic [24:0] ax_r, ay_r;
  logic        negx_r, negy_r, last_r, start_r, zero_r;
  logic [30:0] vx_r, vy_r;
  logic [39:0] pxx_r, pxy_r, pyx_r, pyy_r;
  logic [62:0] sq_r;
  logic [45:0] gh_r, hp_r;
  logic [37:0] press_r;
  logic [31:0] vmag_r;

  logic [31:0] out_xx_r, out_xy_r, out_yx_r, out_yy_r;
  logic [31:0] out_speed_r, out_cmax_r, out_dmax_r;
  logic        out_zero_r, out_done_r;

  logic [24:0] mxu, myu, ax_in, ay_in;
  logic        sat_x, sat_y;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  dsu_req_t    dsu_req;
  dsu_stat_t   dsu_stat;
  logic [31:0] dsu_res;
  logic        fin_load;

  logic [32:0] speed_sum;
  logic [31:0] speed;
  logic [31:0] cm_base, dm_base;
  logic [40:0] sum_xx, sum_yy;
  logic [46:0] press_sum;

  // shared units
  swpf_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  swpf_dsu u_dsu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dsu_req),
    .stat  (dsu_stat),
    .res   (dsu_res)
  );

  // input magnitudes
  always_comb begin
    mxu   = in_momentum_x;
    myu   = (DIMENSION < 2) ? 25'd0 : in_momentum_y;
    ax_in = mxu[24] ? (~mxu + 25'd1) : mxu;
    ay_in = myu[24] ? (~myu + 25'd1) : myu;
  end

  // quotient overflow: |m| << 16 at least 2^31 * h
  assign sat_x = ({14'b0, ax_r} >= {h_r, 15'b0});
  assign sat_y = ({14'b0, ay_r} >= {h_r, 15'b0});

  // final speed and maxima, diagonal flux sums and pressure sum
  always_comb begin
    speed_sum    = {1'b0, vmag_r} + {1'b0, dsu_res};
    speed        = speed_sum[32] ? 32'hFFFF_FFFF : speed_sum[31:0];
    cm_base      = start_r ? 32'd0 : cell_max_r;
    dm_base      = start_r ? 32'd0 : dom_max_r;
    cell_max_nxt = (speed > cm_base) ? speed : cm_base;
    dom_max_nxt  = (speed > dm_base) ? speed : dm_base;
    sum_xx       = {1'b0, pxx_r} + {3'b0, press_r};
    sum_yy       = {1'b0, pyy_r} + {3'b0, press_r};
    press_sum    = {1'b0, hp_r} + {23'b0, mul_p[47:24]};
  end

  // sequencer: next state, multiplier operands, unit requests, output load
  always_comb begin
    state_nxt        = state_r;
    mul_a            = 32'd0;
    mul_b            = 32'd0;
    dsu_req.start    = 1'b0;
    dsu_req.op       = DSU_DIV;
    dsu_req.rem_init = 34'd0;
    dsu_req.x_init   = 64'd0;
    dsu_req.divisor  = h_r;
    fin_load         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DX;
      end
      ST_DX: begin
        dsu_req.start    = 1'b1;
        dsu_req.rem_init = {24'b0, ax_r[24:15]};
        dsu_req.x_init   = {ax_r[14:0], 49'b0};
        state_nxt        = ST_DXW;
      end
      ST_DXW: begin
        if (dsu_stat.done) state_nxt = ST_DY;
      end
      ST_DY: begin
        dsu_req.start    = 1'b1;
        dsu_req.rem_init = {24'b0, ay_r[24:15]};
        dsu_req.x_init   = {ay_r[14:0], 49'b0};
        state_nxt        = ST_DYW;
      end
      ST_DYW: begin
        if (dsu_stat.done) state_nxt = ST_M0;
      end
      ST_M0: begin
        mul_a = {1'b0, vx_r}; mul_b = {7'b0, ax_r}; state_nxt = ST_M1;
      end
      ST_M1: begin
        mul_a = {1'b0, vx_r}; mul_b = {7'b0, ay_r}; state_nxt = ST_M2;
      end
      ST_M2: begin
        mul_a = {1'b0, vy_r}; mul_b = {7'b0, ax_r}; state_nxt = ST_M3;
      end
      ST_M3: begin
        mul_a = {1'b0, vy_r}; mul_b = {7'b0, ay_r}; state_nxt = ST_M4;
      end
      ST_M4: begin
        mul_a = {1'b0, vx_r}; mul_b = {1'b0, vx_r}; state_nxt = ST_M5;
      end
      ST_M5: begin
        mul_a = {1'b0, vy_r}; mul_b = {1'b0, vy_r}; state_nxt = ST_M6;
      end
      ST_M6: begin
        mul_a = {10'b0, gravity_r}; mul_b = {8'b0, h_r}; state_nxt = ST_M7;
      end
      ST_M7: begin
        mul_a = {10'b0, mul_p[45:24]}; mul_b = {8'b0, h_r}; state_nxt = ST_M8;
      end
      ST_M8: begin
        mul_a = {8'b0, gh_r[23:0]}; mul_b = {8'b0, h_r}; state_nxt = ST_M9;
      end
      ST_M9: begin
        state_nxt = ST_SQA;
      end
      ST_SQA: begin
        dsu_req.start  = 1'b1;
        dsu_req.op     = DSU_SQRT;
        dsu_req.x_init = {1'b0, sq_r};
        state_nxt      = ST_SQAW;
      end
      ST_SQAW: begin
        if (dsu_stat.done) state_nxt = ST_SQB;
      end
      ST_SQB: begin
        dsu_req.start  = 1'b1;
        dsu_req.op     = DSU_SQRT;
        dsu_req.x_init = {18'b0, gh_r};
        state_nxt      = ST_SQBW;
      end
      ST_SQBW: begin
        if (dsu_stat.done) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          fin_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      gravity_r   <= GRAVITY_RESET;
      cell_max_r  <= 32'd0;
      dom_max_r   <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) gravity_r <= cfg_wdata;
      if (fin_load) begin
        cell_max_r  <= last_r ? 32'd0 : cell_max_nxt;
        dom_max_r   <= dom_max_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      h_r     <= in_height;
      ax_r    <= ax_in;
      ay_r    <= ay_in;
      negx_r  <= mxu[24];
      negy_r  <= myu[24];
      last_r  <= in_last_in_cell;
      start_r <= in_start_sweep;
      zero_r  <= (in_height == 24'd0);
    end
    if (state_r == ST_DXW && dsu_stat.done)
      vx_r <= zero_r ? 31'd0 : (sat_x ? 31'h7FFF_FFFF : dsu_res[30:0]);
    if (state_r == ST_DYW && dsu_stat.done)
      vy_r <= zero_r ? 31'd0 : (sat_y ? 31'h7FFF_FFFF : dsu_res[30:0]);
    case (state_r)
      ST_M1: pxx_r <= mul_p[55:16];
      ST_M2: pxy_r <= mul_p[55:16];
      ST_M3: pyx_r <= mul_p[55:16];
      ST_M4: pyy_r <= mul_p[55:16];
      ST_M5: sq_r  <= {1'b0, mul_p[61:0]};
      ST_M6: sq_r  <= sq_r + {1'b0, mul_p[61:0]};
      ST_M7: gh_r  <= mul_p[45:0];
      ST_M8: hp_r  <= mul_p[45:0];
      ST_M9: press_r <= press_sum[46:9];
      default: ;
    endcase
    if (state_r == ST_SQAW && dsu_stat.done) vmag_r <= dsu_res;
  end

  // output word register
  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_xx_r    <= sat_pos(sum_xx);
      out_xy_r    <= sat_sm(negx_r ^ negy_r, pxy_r);
      out_yx_r    <= sat_sm(negx_r ^ negy_r, pyx_r);
      out_yy_r    <= (DIMENSION < 2) ? 32'd0 : sat_pos(sum_yy);
      out_speed_r <= speed;
      out_cmax_r  <= cell_max_nxt;
      out_dmax_r  <= dom_max_nxt;
      out_zero_r  <= zero_r;
      out_done_r  <= last_r;
    end
  end

  assign in_ready             = (state_r == ST_IDLE);
  assign out_valid            = out_valid_r;
  assign out_flux_xx          = out_xx_r;
  assign out_flux_xy          = out_xy_r;
  assign out_flux_yx          = out_yx_r;
  assign out_flux_yy          = out_yy_r;
  assign out_wave_speed       = out_speed_r;
  assign out_cell_max_speed   = out_cmax_r;
  assign out_domain_max_speed = out_dmax_r;
  assign out_zero_height      = out_zero_r;
  assign out_cell_done        = out_done_r;

  // checks
  a_idle_unit_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !dsu_stat.busy)
    else $error("divide/sqrt unit busy while idle");

  a_cell_le_domain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_cell_max_speed <= out_domain_max_speed)
    else $error("cell maximum above domain maximum");

  a_speed_le_cell: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_wave_speed <= out_cell_max_speed)
    else $error("wave speed above cell maximum");

  a_zero_height: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_height) |-> (out_wave_speed == 32'd0 && out_flux_xy == 32'sd0))
    else $error("nonzero result for zero height");

endmodule
